[src/sfqb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfqb_pkg: shared types and constants
// Types, codes and interval helpers for the sorted file queue batcher.
// ----------------------------------------------------------------------------
package sfqb_pkg;
    localparam int TABLE_DEPTH = 64;
    localparam int MAX_BATCH   = 64;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int BAT_W       = $clog2(MAX_BATCH + 1);

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_ENTRY  = 2'd1;
    localparam logic [1:0] KIND_NONE   = 2'd2;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_DUP      = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [1:0] PRJ_LONG  = 2'd0;
    localparam logic [1:0] PRJ_SHORT = 2'd1;
    localparam logic [1:0] TYP_RIBS  = 2'd0;
    localparam logic [1:0] TYP_UPD   = 2'd1;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_TAKE = 1'b1;

    localparam logic [15:0] LONG_RST  = 16'd900;
    localparam logic [15:0] SHORT_RST = 16'd300;
    localparam logic REG_LONG  = 1'b0;
    localparam logic REG_SHORT = 1'b1;

    typedef struct packed {
        logic        action;
        logic [30:0] file_time;
        logic [1:0]  project;
        logic [7:0]  collector;
        logic [1:0]  file_type;
        logic [15:0] file_tag;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  push_status;
        logic [30:0] out_time;
        logic [1:0]  out_project;
        logic [7:0]  out_collector;
        logic [1:0]  out_type;
        logic [15:0] out_tag;
        logic        last;
        logic        queue_empty;
    } t_out;

    typedef struct packed {
        logic [30:0] t;
        logic [1:0]  project;
        logic [7:0]  collector;
        logic [1:0]  ftype;
        logic [15:0] tag;
    } t_entry;

    // Control to the cell row.
    typedef struct packed {
        logic         ins;      // insert new entry at ins_pos
        logic [CNT_W-1:0] ins_pos;
        logic         shl;      // shift row toward head by one
    } t_row_ctl;

    // interval in signed 34-bit
    function automatic logic signed [33:0] ival_lo(t_entry e, logic [15:0] lo_off,
                                                  logic [15:0] sh_off);
        logic signed [33:0] t, o;
        t = $signed({3'b000, e.t});
        o = (e.project == PRJ_LONG) ? $signed({18'd0, lo_off}) : $signed({18'd0, sh_off});
        if (e.project != PRJ_LONG && e.project != PRJ_SHORT) return '0;
        if (e.ftype == TYP_RIBS) return t - o;
        if (e.ftype == TYP_UPD) return t;
        return '0;
    endfunction

    function automatic logic signed [33:0] ival_hi(t_entry e, logic [15:0] lo_off,
                                                  logic [15:0] sh_off);
        logic signed [33:0] t, o;
        t = $signed({3'b000, e.t});
        o = (e.project == PRJ_LONG) ? $signed({18'd0, lo_off}) : $signed({18'd0, sh_off});
        if (e.project != PRJ_LONG && e.project != PRJ_SHORT) return '0;
        if (e.ftype == TYP_RIBS || e.ftype == TYP_UPD) return t + o;
        return '0;
    endfunction
endpackage
`default_nettype wire

[src/sfqb_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfqb_cell: one table slot
// Holds one entry; loads the new entry, its left neighbor, or its right
// neighbor as the row shifts.
// ----------------------------------------------------------------------------
module sfqb_cell import sfqb_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_ld_new,
    input  wire logic   i_ld_prev,
    input  wire logic   i_ld_next,
    input  wire t_entry i_new,
    input  wire t_entry i_prev,
    input  wire t_entry i_next,
    output t_entry      o_entry
);
    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        priority if (i_ld_new) begin
            r_entry <= i_new;
        end else if (i_ld_prev) begin
            r_entry <= i_prev;
        end else if (i_ld_next) begin
            r_entry <= i_next;
        end else begin
            r_entry <= r_entry;
        end
    end

    assign o_entry = r_entry;
endmodule
`default_nettype wire

[src/sfqb_row.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfqb_row: chain of slot cells
// Insert opens a gap at a position; shift moves all entries one toward head.
// ----------------------------------------------------------------------------
module sfqb_row import sfqb_pkg::*; (
    input  wire logic     i_clk,
    input  wire t_row_ctl i_ctl,
    input  wire t_entry   i_new,
    output t_entry        o_slot [TABLE_DEPTH]
);
    t_entry w_slot [TABLE_DEPTH];

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic   w_new, w_prev, w_next;
        t_entry w_p, w_n;
        assign w_new  = i_ctl.ins && (i_ctl.ins_pos == CNT_W'(g));
        assign w_prev = i_ctl.ins && (i_ctl.ins_pos < CNT_W'(g));
        assign w_next = i_ctl.shl;
        assign w_p = (g == 0) ? w_slot[0] : w_slot[(g == 0) ? 0 : g - 1];
        assign w_n = (g == TABLE_DEPTH - 1) ? w_slot[g]
                                            : w_slot[(g == TABLE_DEPTH - 1) ? g : g + 1];
        sfqb_cell u_cell (
            .i_clk    (i_clk),
            .i_ld_new (w_new),
            .i_ld_prev(w_prev),
            .i_ld_next(w_next),
            .i_new    (i_new),
            .i_prev   (w_p),
            .i_next   (w_n),
            .o_entry  (w_slot[g])
        );
    end

    assign o_slot = w_slot;
endmodule
`default_nettype wire

[src/sorted_file_queue_batcher_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_file_queue_batcher_unit: sorted file table with batch release
// Channel | signals                           | accepted when
// in      | i_start, o_busy, i_in             | i_start && !o_busy
// out     | o_valid, o_out                    | o_valid (no stall)
// cfg     | i_cfg_valid, o_cfg_ready, idx/dat | i_cfg_valid && o_cfg_ready
// Push: scans slots from the head to the stop point (up to fill_count + 1),
// then inserts and strobes the status, or strobes a duplicate or full status.
// Take: walks the head entries that join the batch, then shifts them out
// toward the head, or strobes a none result; o_busy holds through the last
// strobe. Reset clears fill count and presets offsets; the table needs no
// clearing. The receiver cannot stall; cfg is taken only while idle.
// ----------------------------------------------------------------------------
module sorted_file_queue_batcher_unit import sfqb_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire t_in         i_in,
    output logic             o_busy,
    output logic             o_valid,
    output t_out             o_out,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output logic             o_cfg_ready
);
    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_INS, S_WALK, S_SEND} t_state;

    t_state             r_state;
    t_in                r_cmd;
    logic [CNT_W-1:0]   r_fill, r_idx;
    logic [BAT_W-1:0]   r_n;
    logic [15:0]        r_long, r_short;
    logic signed [33:0] r_mark;
    logic               r_valid;
    t_out               r_out;
    t_row_ctl           w_ctl;
    t_entry             w_slot [TABLE_DEPTH];
    t_entry             w_new, w_cur, w_head;
    logic [IDX_W-1:0]   w_sel;
    logic signed [33:0] w_lo, w_hi;
    logic               w_stop, w_dup, w_take, w_last;

    function automatic t_out status_res(input logic [1:0] st, input logic empty);
        t_out r;
        r             = '0;
        r.kind        = KIND_STATUS;
        r.push_status = st;
        r.last        = 1'b1;
        r.queue_empty = empty;
        return r;
    endfunction

    function automatic t_out none_res(input logic empty);
        t_out r;
        r             = '0;
        r.kind        = KIND_NONE;
        r.last        = 1'b1;
        r.queue_empty = empty;
        return r;
    endfunction

    function automatic t_out entry_res(input t_entry e, input logic fin, input logic empty);
        t_out r;
        r               = '0;
        r.kind          = KIND_ENTRY;
        r.out_time      = e.t;
        r.out_project   = e.project;
        r.out_collector = e.collector;
        r.out_type      = e.ftype;
        r.out_tag       = e.tag;
        r.last          = fin;
        r.queue_empty   = empty;
        return r;
    endfunction

    assign w_new = '{t: r_cmd.file_time, project: r_cmd.project,
                     collector: r_cmd.collector, ftype: r_cmd.file_type,
                     tag: r_cmd.file_tag};
    assign w_sel  = r_idx[IDX_W-1:0];
    assign w_cur  = w_slot[w_sel];
    assign w_head = w_slot[0];
    assign w_lo   = ival_lo(w_cur, r_long, r_short);
    assign w_hi   = ival_hi(w_cur, r_long, r_short);

    assign w_dup  = (w_cur.t == r_cmd.file_time) && (w_cur.collector == r_cmd.collector)
                    && (w_cur.project == r_cmd.project) && (w_cur.ftype == r_cmd.file_type);
    assign w_stop = (r_idx == r_fill) || (w_cur.t > r_cmd.file_time)
                    || ((w_cur.t == r_cmd.file_time) && (r_cmd.file_type == TYP_RIBS)
                        && (w_cur.ftype == TYP_UPD));
    assign w_take = (r_idx < r_fill) && (r_idx < CNT_W'(MAX_BATCH)) && (w_lo < r_mark);
    assign w_last = ((r_idx + CNT_W'(1)) == CNT_W'(r_n));

    always_comb begin
        w_ctl         = '0;
        w_ctl.ins_pos = r_idx;
        w_ctl.ins     = (r_state == S_INS);
        w_ctl.shl     = (r_state == S_SEND);
    end

    sfqb_row u_row (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_new (w_new),
        .o_slot(w_slot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_valid <= 1'b0;
            r_out   <= '0;
            r_long  <= LONG_RST;
            r_short <= SHORT_RST;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_LONG) r_long <= i_cfg_data;
                else r_short <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start && !o_busy) begin
                        r_cmd <= i_in;
                        r_idx <= '0;
                        r_n   <= '0;
                        r_mark <= ival_hi(w_head, r_long, r_short);
                        r_state <= (i_in.action == ACT_PUSH) ? S_SCAN : S_WALK;
                    end
                end
                S_SCAN: begin
                    if (w_stop) begin
                        if (r_fill == CNT_W'(TABLE_DEPTH)) begin
                            r_out   <= status_res(ST_FULL, 1'b0);
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_INS;
                        end
                    end else if (w_dup) begin
                        r_out   <= status_res(ST_DUP, 1'b0);
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_INS: begin
                    r_fill  <= r_fill + 1'b1;
                    r_out   <= status_res(ST_INSERTED, 1'b0);
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_WALK: begin
                    if (w_take) begin
                        if (w_hi > r_mark) r_mark <= w_hi;
                        r_idx <= r_idx + 1'b1;
                    end else if (r_idx == '0) begin
                        r_out   <= none_res(r_fill == '0);
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_n     <= BAT_W'(r_idx);
                        r_idx   <= '0;
                        r_state <= S_SEND;
                    end
                end
                S_SEND: begin
                    r_out   <= entry_res(w_head, w_last, r_fill == CNT_W'(r_n));
                    r_valid <= 1'b1;
                    r_idx   <= r_idx + 1'b1;
                    if (w_last) begin
                        r_fill  <= r_fill - CNT_W'(r_n);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid     = r_valid;
    assign o_out       = r_out;
    assign o_busy      = (r_state != S_IDLE) || r_valid;
    assign o_cfg_ready = !o_busy && !i_start;
endmodule
`default_nettype wire

[src/sfqb_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfqb_checker: port-level checks
// Watches the top-level ports for handshake rules and last flags on results.
// ----------------------------------------------------------------------------
module sfqb_checker import sfqb_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_start,
    input wire logic o_busy,
    input wire logic o_valid,
    input wire t_out o_out
);
    a_no_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_busy && !$past(o_busy)) |-> !o_valid) else $error("result while idle");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("start not taken");
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.kind != KIND_ENTRY) |-> o_out.last) else $error("last");
endmodule

bind sorted_file_queue_batcher_unit sfqb_checker u_sfqb_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start),
    .o_busy(o_busy), .o_valid(o_valid), .o_out(o_out)
);
`default_nettype wire
